>>> hdl/cartridge_bank_mapper_core_defines.svh
// Assertion macros used by the cartridge bank mapper checker.
`ifndef CARTRIDGE_BANK_MAPPER_CORE_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_CORE_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define CBM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cartridge bank mapper check failed");

// Next-cycle implication, quiet while reset is high.
`define CBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cartridge bank mapper check failed");

// Next-cycle implication that also holds across reset.
`define CBM_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cartridge bank mapper check failed");

`endif

>>> hdl/cbm_pkg.sv
// Types and constants of the cartridge bank mapper.
`timescale 1ns / 1ps
`default_nettype none
package cbm_pkg;

  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int ROM_ADDR_W = 21;
  localparam int RAM_ADDR_W = 15;
  localparam int ROM_BANK_W = 7;
  localparam int RAM_BANK_W = 2;
  localparam int LOW_BANK_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [1:0] {
    OUT_ROM = 2'd0,
    OUT_RAM = 2'd1,
    OUT_REG = 2'd2,
    OUT_BAD = 2'd3
  } outcome_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BANKING_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_MASK = 2'd2;

  // 8 KiB regions of the CPU bus, address[15:13]
  localparam logic [2:0] REGION_RAM_EN   = 3'd0;
  localparam logic [2:0] REGION_ROM_LOW  = 3'd1;
  localparam logic [2:0] REGION_UPPER    = 3'd2;
  localparam logic [2:0] REGION_BANKED_A = 3'd3;
  localparam logic [2:0] REGION_CART_RAM = 3'd5;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

  localparam logic [ROM_BANK_W-1:0] ROM_MASK_RESET = 7'h7F;
  localparam logic [RAM_BANK_W-1:0] RAM_MASK_RESET = 2'h3;
  localparam logic [LOW_BANK_W-1:0] LOW_BANK_RESET = 5'd1;

  typedef struct packed {
    logic                  banking_mode;
    logic [ROM_BANK_W-1:0] rom_bank_mask;
    logic [RAM_BANK_W-1:0] ram_bank_mask;
  } cfg_t;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    outcome_t              outcome;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [RAM_ADDR_W-1:0] ram_address;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/cbm_xlate.sv
// Bank registers and address translation of one bus request.
`timescale 1ns / 1ps
`default_nettype none
module cbm_xlate (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire cbm_pkg::req_t   req,
  input  wire cbm_pkg::cfg_t   cfg,
  output cbm_pkg::result_t     res
);
  import cbm_pkg::*;

  logic                  ram_enabled;
  logic [LOW_BANK_W-1:0] rom_bank_low;
  logic [RAM_BANK_W-1:0] bank_upper;

  logic [2:0]            region;
  logic [LOW_BANK_W-1:0] low_eff;
  logic [ROM_BANK_W-1:0] rom_bank;
  logic [RAM_BANK_W-1:0] ram_bank;

  assign region   = req.address[ADDR_W-1:ADDR_W-3];
  // A low bank of zero reads as one
  assign low_eff  = (rom_bank_low == '0) ? LOW_BANK_RESET : rom_bank_low;
  assign rom_bank = {bank_upper, low_eff} & cfg.rom_bank_mask;
  assign ram_bank = cfg.banking_mode ? (bank_upper & cfg.ram_bank_mask) : '0;

  always_comb begin
    res.outcome     = OUT_BAD;
    res.rom_address = '0;
    res.ram_address = '0;
    if (req.req_type) begin
      case (region)
        REGION_RAM_EN, REGION_ROM_LOW, REGION_UPPER: res.outcome = OUT_REG;
        default: res.outcome = OUT_BAD;
      endcase
    end else begin
      case (region)
        REGION_RAM_EN, REGION_ROM_LOW: begin
          res.outcome     = OUT_ROM;
          res.rom_address = {{ROM_BANK_W{1'b0}}, req.address[13:0]};
        end
        REGION_UPPER, REGION_BANKED_A: begin
          res.outcome     = OUT_ROM;
          res.rom_address = {rom_bank, req.address[13:0]};
        end
        REGION_CART_RAM: begin
          if (ram_enabled) begin
            res.outcome     = OUT_RAM;
            res.ram_address = {ram_bank, req.address[12:0]};
          end
        end
        default: res.outcome = OUT_BAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enabled  <= 1'b0;
      rom_bank_low <= LOW_BANK_RESET;
      bank_upper   <= '0;
    end else if (accept && req.req_type) begin
      case (region)
        REGION_RAM_EN:  ram_enabled  <= (req.write_data[3:0] == RAM_ENABLE_KEY);
        REGION_ROM_LOW: rom_bank_low <= req.write_data[LOW_BANK_W-1:0];
        REGION_UPPER:   bank_upper   <= req.write_data[RAM_BANK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/cartridge_bank_mapper_core.sv
// Top level of the cartridge bank mapper: request channel, result channel, config port.
// Usage
//   Request channel: in_valid with req_type, address and write_data; the request is
//   taken at a rising edge with in_valid high and in_stall low. Hold the request
//   steady while in_stall is high.
//   Result channel: out_valid with outcome, rom_address and ram_address; the result
//   is taken at a rising edge with out_valid high and out_stall low. One result
//   comes out for every request, in request order.
//   Config port: cfg_valid, cfg_index, cfg_data, with cfg_ready always high.
//   Write it only while no request is in flight.
// Results and throughput
//   Results are registered in the output or skid entry; one request a cycle is sustained
//   while out_stall is low. Bank register writes take effect for the very next request.
//   The rate is set by the single translation stage and a two-entry output buffer.
// Stall and reset
//   When out_stall holds a result, one more request is parked in the skid entry and
//   in_stall rises only after that, from a register.
//   Synchronous reset empties both entries, clears RAM enable, sets the low bank to
//   one, the upper bank and banking mode to zero and both masks to all ones.
`timescale 1ns / 1ps
`default_nettype none
module cartridge_bank_mapper_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                req_type,
  input  wire logic [cbm_pkg::ADDR_W-1:0]          address,
  input  wire logic [cbm_pkg::DATA_W-1:0]          write_data,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               outcome,
  output logic [cbm_pkg::ROM_ADDR_W-1:0]           rom_address,
  output logic [cbm_pkg::RAM_ADDR_W-1:0]           ram_address,
  // config port
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cbm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [cbm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cbm_pkg::*;

  cfg_t    cfg;
  req_t    req;
  result_t new_res;
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  logic    accept;
  logic    out_free;

  assign req      = '{req_type: req_type, address: address, write_data: write_data};
  // Stall only once the skid entry is occupied
  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  // Output register can load when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  assign cfg_ready = 1'b1;

  // Config registers; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.banking_mode  <= 1'b0;
      cfg.rom_bank_mask <= ROM_MASK_RESET;
      cfg.ram_bank_mask <= RAM_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BANKING_MODE:  cfg.banking_mode  <= cfg_data[0];
        CFG_ROM_BANK_MASK: cfg.rom_bank_mask <= cfg_data[ROM_BANK_W-1:0];
        CFG_RAM_BANK_MASK: cfg.ram_bank_mask <= cfg_data[RAM_BANK_W-1:0];
        default: ;
      endcase
    end
  end

  cbm_xlate u_xlate (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .cfg    (cfg),
    .res    (new_res)
  );

  // Control: output entry and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      // Advance the skid entry first, else load the fresh result
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= new_res;
      end
    end else if (accept) begin
      skid_res <= new_res;
    end
  end

  assign outcome     = out_res.outcome;
  assign rom_address = out_res.rom_address;
  assign ram_address = out_res.ram_address;

endmodule
`default_nettype wire

>>> hdl/cbm_checker.sv
// Port-level checks of the cartridge bank mapper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "cartridge_bank_mapper_core_defines.svh"
module cbm_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic                           req_type,
  input  wire logic [cbm_pkg::ADDR_W-1:0]     address,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic [1:0]                     outcome,
  input  wire logic [cbm_pkg::ROM_ADDR_W-1:0] rom_address,
  input  wire logic [cbm_pkg::RAM_ADDR_W-1:0] ram_address
);
  import cbm_pkg::*;

  logic                  take_now;
  logic                  bank0_take;
  logic [ROM_ADDR_W-1:0] bank0_addr;
  logic                  held;

  assign take_now   = in_valid && !in_stall && (!out_valid || !out_stall);
  // Fixed bank read: the ROM address is the bus offset, zero-extended
  assign bank0_take = take_now && !req_type && (address[15:14] == 2'b00);
  assign bank0_addr = ROM_ADDR_W'(address[13:0]);
  assign held       = out_valid && out_stall;

  `CBM_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !out_valid && !in_stall)
  `CBM_ASSERT_NEXT(a_result_follows, take_now, out_valid)
  `CBM_ASSERT_NEXT(a_bank0_read, bank0_take, outcome == OUT_ROM && rom_address == $past(bank0_addr))
  `CBM_ASSERT_SAME(a_ram_addr_only_ram, out_valid && outcome != OUT_RAM, ram_address == '0)
  `CBM_ASSERT_NEXT(a_held_result, held, out_valid && $stable(outcome) && $stable(rom_address))

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .req_type    (req_type),
  .address     (address),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .outcome     (outcome),
  .rom_address (rom_address),
  .ram_address (ram_address)
);
`default_nettype wire

>>> tb/sv/cartridge_bank_mapper_core_test.sv
// Self-checking testbench of the cartridge bank mapper: directed and random bus requests.
`timescale 1ns / 1ps
module cartridge_bank_mapper_core_test;
  import cbm_pkg::*;

  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int QUIET_LIMIT  = 2000;
  // Length of the deliberate long hold-off on the result channel.
  localparam int LONG_HOLD    = 40;
  // Cycles to let pass after the last result before touching the config port.
  localparam int SETTLE_TICKS = 4;
  localparam int PHASE_ITEMS  = 125;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  req_type = 1'b0;
  logic [ADDR_W-1:0]     address = '0;
  logic [DATA_W-1:0]     write_data = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            outcome;
  logic [ROM_ADDR_W-1:0] rom_address;
  logic [RAM_ADDR_W-1:0] ram_address;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Requests waiting for the driver, and translations waiting for the block to return them.
  req_t    pending_requests[$];
  result_t awaited_translations[$];
  req_t    offered_request;
  result_t due_translation;
  int      mismatch_count = 0;

  // Own copy of the mapper's registers and of its configuration.
  logic                  map_ram_on     = 1'b0;
  logic [LOW_BANK_W-1:0] map_low_bank   = LOW_BANK_RESET;
  logic [RAM_BANK_W-1:0] map_upper_bank = '0;
  logic                  cfg_mode       = 1'b0;
  logic [ROM_BANK_W-1:0] cfg_rom_mask   = ROM_MASK_RESET;
  logic [RAM_BANK_W-1:0] cfg_ram_mask   = RAM_MASK_RESET;

  // Idle rates in percent, set per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long hold-off requests: the stimulus bumps the count, the stall process notices.
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  cartridge_bank_mapper_core DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .address     (address),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .outcome     (outcome),
    .rom_address (rom_address),
    .ram_address (ram_address),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Translate one request and advance the bank registers as the mapper would.
  function automatic result_t translate_request(input req_t acc);
    result_t               res;
    logic [LOW_BANK_W-1:0] low;
    logic [ROM_BANK_W-1:0] bank;
    logic [RAM_BANK_W-1:0] ram_bank;
    res = '0;
    if (acc.req_type) begin
      res.outcome = OUT_REG;
      case (acc.address[15:13])
        REGION_RAM_EN: begin
          map_ram_on = (acc.write_data[3:0] == RAM_ENABLE_KEY);
        end
        REGION_ROM_LOW: begin
          map_low_bank = acc.write_data[LOW_BANK_W-1:0];
        end
        REGION_UPPER: begin
          map_upper_bank = acc.write_data[RAM_BANK_W-1:0];
        end
        default: begin
          // mode select, RAM writes and everything above: refused, no effect
          res.outcome = OUT_BAD;
        end
      endcase
    end else if (!acc.address[15]) begin
      res.outcome = OUT_ROM;
      if (acc.address[14]) begin
        // a low bank of zero reads as one; mask only after that
        low  = (map_low_bank == '0) ? LOW_BANK_RESET : map_low_bank;
        bank = {map_upper_bank, low} & cfg_rom_mask;
      end else begin
        bank = '0;
      end
      res.rom_address = {bank, acc.address[13:0]};
    end else if (acc.address[15:13] == REGION_CART_RAM && map_ram_on) begin
      res.outcome     = OUT_RAM;
      ram_bank        = cfg_mode ? (map_upper_bank & cfg_ram_mask) : '0;
      res.ram_address = {ram_bank, acc.address[12:0]};
    end else begin
      res.outcome = OUT_BAD;
    end
    return res;
  endfunction

  // Mostly well-aimed requests (bank writes, banked reads, RAM reads), some pure noise.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick         = $urandom_range(99);
    r.req_type   = 1'b1;
    r.address    = 16'($urandom);
    r.write_data = 8'($urandom);
    if (pick < 12) begin
      r.address = {REGION_RAM_EN, 13'($urandom)};
      if ($urandom_range(1) == 0) r.write_data[3:0] = RAM_ENABLE_KEY;
    end else if (pick < 27) begin
      r.address = {REGION_ROM_LOW, 13'($urandom)};
      if ($urandom_range(3) == 0) r.write_data[LOW_BANK_W-1:0] = '0;
    end else if (pick < 37) begin
      r.address = {REGION_UPPER, 13'($urandom)};
    end else if (pick < 62) begin
      r.req_type = 1'b0;
      r.address  = {2'b01, 14'($urandom)};
    end else if (pick < 70) begin
      r.req_type = 1'b0;
      r.address  = {2'b00, 14'($urandom)};
    end else if (pick < 85) begin
      r.req_type = 1'b0;
      r.address  = {REGION_CART_RAM, 13'($urandom)};
    end else begin
      r.req_type = 1'($urandom);
    end
    return r;
  endfunction

  task automatic queue_request(input logic t, input logic [15:0] a, input logic [7:0] d);
    req_t r;
    r.req_type   = t;
    r.address    = a;
    r.write_data = d;
    pending_requests.push_back(r);
  endtask

  // Hold until every request has gone in and every translation has come back, then settle.
  // Sample on the falling edge so the driver's and monitor's updates have all landed.
  task automatic wait_until_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || awaited_translations.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    // only the low bits of each register are kept
    case (idx)
      CFG_BANKING_MODE:  cfg_mode     = val[0];
      CFG_ROM_BANK_MASK: cfg_rom_mask = val[ROM_BANK_W-1:0];
      CFG_RAM_BANK_MASK: cfg_ram_mask = val[RAM_BANK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_up_phase(input logic [CFG_DATA_W-1:0] mode_raw, rom_raw, ram_raw,
                              input int send_pct, recv_pct);
    wait_until_drained();
    write_register(CFG_BANKING_MODE, mode_raw);
    write_register(CFG_ROM_BANK_MASK, rom_raw);
    write_register(CFG_RAM_BANK_MASK, ram_raw);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic queue_random_requests();
    repeat (PHASE_ITEMS) pending_requests.push_back(random_request());
  endtask

  // Request driver: present the front of the queue, hold it while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_translations.push_back(translate_request(offered_request));
      end
      // the channel is free when nothing was offered or the offer was just taken
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_request = pending_requests.pop_front();
          in_valid   <= 1'b1;
          req_type   <= offered_request.req_type;
          address    <= offered_request.address;
          write_data <= offered_request.write_data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall: a long hold-off when asked, otherwise random stalls at the phase rate.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result monitor: compare each accepted result with the oldest awaited translation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (awaited_translations.size() == 0) begin
        $display("%0t: result with nothing awaited, expected none, got outcome %0d rom %h ram %h",
                 $time, outcome, rom_address, ram_address);
        mismatch_count++;
      end else begin
        due_translation = awaited_translations.pop_front();
        if (outcome !== due_translation.outcome) begin
          $display("%0t: outcome expected %0d, got %0d",
                   $time, due_translation.outcome, outcome);
          mismatch_count++;
        end
        if (rom_address !== due_translation.rom_address) begin
          $display("%0t: rom_address expected %h, got %h",
                   $time, due_translation.rom_address, rom_address);
          mismatch_count++;
        end
        if (ram_address !== due_translation.ram_address) begin
          $display("%0t: ram_address expected %h, got %h",
                   $time, due_translation.ram_address, ram_address);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: drop the run when no channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset configuration.
    send_idle_pct = 8;
    recv_idle_pct = 62;
    queue_request(1'b0, 16'h0000, 8'h00);  // bank 0, lowest address
    queue_request(1'b0, 16'h3FFF, 8'hFF);  // bank 0, top
    queue_request(1'b0, 16'h4000, 8'h00);  // switchable bank at reset value
    queue_request(1'b0, 16'hA000, 8'h00);  // RAM read while disabled
    queue_request(1'b1, 16'h0000, 8'h0A);  // enable RAM
    queue_request(1'b0, 16'hA000, 8'hFF);
    queue_request(1'b0, 16'hBFFF, 8'h00);
    queue_request(1'b1, 16'h2000, 8'h00);  // low bank zero
    queue_request(1'b0, 16'h7FFF, 8'h00);  // reads as bank one
    queue_request(1'b1, 16'h3FFF, 8'hFF);  // low bank all ones
    queue_request(1'b1, 16'h4000, 8'hFF);  // upper bits all ones
    queue_request(1'b0, 16'h4000, 8'h00);  // highest ROM bank
    queue_request(1'b1, 16'h5FFF, 8'h02);
    queue_request(1'b1, 16'h6000, 8'hFF);  // mode select refused
    queue_request(1'b1, 16'h7FFF, 8'h01);
    queue_request(1'b1, 16'hA000, 8'h55);  // RAM write refused
    queue_request(1'b1, 16'hBFFF, 8'hAA);
    queue_request(1'b0, 16'h8000, 8'h00);  // unmapped reads
    queue_request(1'b0, 16'hC000, 8'h00);
    queue_request(1'b0, 16'hFFFF, 8'hFF);
    queue_request(1'b1, 16'hFFFF, 8'hFF);
    queue_request(1'b1, 16'h1FFF, 8'hFA);  // key in low nibble enables
    queue_request(1'b1, 16'h0000, 8'hA0);  // key in high nibble disables
    queue_request(1'b0, 16'hA123, 8'h00);
    queue_request(1'b0, 16'h2000, 8'hAA);

    // Random phases: sender idles lightly and receiver heavily, then the reverse, then none.
    set_up_phase(7'h7F, 7'h7F, 7'h7F, 8, 62);
    queue_random_requests();
    set_up_phase(7'h00, 7'h00, 7'h00, 8, 62);
    queue_random_requests();
    set_up_phase(7'h55, 7'h1F, 7'h01, 62, 8);
    queue_random_requests();
    set_up_phase(7'h2A, 7'h03, 7'h7E, 62, 8);
    queue_random_requests();
    set_up_phase(7'($urandom), 7'($urandom), 7'($urandom), 0, 0);
    queue_random_requests();
    // Hold off the result side while requests keep coming, to fill the block.
    hold_asks++;
    set_up_phase(7'h01, 7'h7F, 7'h03, 0, 0);
    queue_random_requests();

    wait_until_drained();
    if (mismatch_count == 0 && awaited_translations.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> cartridge_bank_mapper_core.f
+incdir+hdl
hdl/cbm_pkg.sv
hdl/cbm_xlate.sv
hdl/cartridge_bank_mapper_core.sv
hdl/cbm_checker.sv
tb/sv/cartridge_bank_mapper_core_test.sv
